// File: design/hpg_pkg.sv
// ----------------------------------------------------------------------------
// hpg_pkg
// Shared types and constants for the core hotplug governor: field widths,
// operation codes, register indexes and the structs passed between modules.
// ----------------------------------------------------------------------------
package hpg_pkg;

    localparam int FREQ_W     = 22;
    localparam int CNT_W      = 10;
    localparam int MASK_W     = 4;
    localparam int IVL_W      = 8;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int NUM_LIMITS = 3;

    // Input word kinds
    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_DISP_OFF = 2'd1,
        KIND_DISP_ON  = 2'd2,
        KIND_UNUSED   = 2'd3
    } kind_t;

    // Result actions
    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_UP   = 2'd1,
        ACT_DOWN = 2'd2,
        ACT_RSVD = 2'd3
    } action_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ENABLE    = 3'd0,
        REG_THRESHOLD = 3'd1,
        REG_UP_1      = 3'd2,
        REG_UP_2      = 3'd3,
        REG_UP_3      = 3'd4,
        REG_DOWN_1    = 3'd5,
        REG_DOWN_2    = 3'd6,
        REG_DOWN_3    = 3'd7
    } reg_idx_t;

    // Counter limits and reset values
    localparam logic signed [CNT_W-1:0] CNT_MIN    = -10'sd512;
    localparam logic signed [CNT_W-1:0] CNT_MAX    = 10'sd511;
    localparam logic signed [CNT_W-1:0] WAKE_COUNT = -10'sd60;

    localparam logic [FREQ_W-1:0] RST_THRESHOLD = 22'd1267200;
    localparam logic [CNT_W-1:0]  RST_UP_1      = 10'h3D3;   // -45
    localparam logic [CNT_W-1:0]  RST_UP_2      = 10'h3EC;   // -20
    localparam logic [CNT_W-1:0]  RST_UP_3      = 10'h000;
    localparam logic [CNT_W-1:0]  RST_DOWN_1    = 10'd40;
    localparam logic [CNT_W-1:0]  RST_DOWN_2    = 10'd100;
    localparam logic [CNT_W-1:0]  RST_DOWN_3    = 10'd170;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic                                enable;
        logic [FREQ_W-1:0]                   threshold;
        logic [NUM_LIMITS-1:0][CNT_W-1:0]    up_limit;
        logic [NUM_LIMITS-1:0][CNT_W-1:0]    down_limit;
    } hpg_cfg_t;

    // Per-core flags captured in the first stage
    typedef struct packed {
        logic online;
        logic at_max;
        logic at_low;
    } hpg_flags_t;

    // Decision enables broadcast to the cells
    typedef struct packed {
        logic wake_en;
        logic down_en;
    } hpg_ctrl_t;

    // Per-cell decision outcome
    typedef struct packed {
        logic up;
        logic down;
    } hpg_fire_t;

endpackage

// File: design/hpg_if.sv
// ----------------------------------------------------------------------------
// hpg_if
// Valid/ready channels of the governor: the request word (one per event)
// and the response word (one decision per event).
// ----------------------------------------------------------------------------
interface hpg_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic [hpg_pkg::MASK_W-1:0] online_mask;
    logic [hpg_pkg::MASK_W-1:0] policy_ok_mask;
    logic [hpg_pkg::FREQ_W-1:0] cur_freq_0;
    logic [hpg_pkg::FREQ_W-1:0] cur_freq_1;
    logic [hpg_pkg::FREQ_W-1:0] cur_freq_2;
    logic [hpg_pkg::FREQ_W-1:0] cur_freq_3;
    logic [hpg_pkg::FREQ_W-1:0] min_freq_1;
    logic [hpg_pkg::FREQ_W-1:0] min_freq_2;
    logic [hpg_pkg::FREQ_W-1:0] min_freq_3;

    modport source (
        output valid, kind, online_mask, policy_ok_mask,
               cur_freq_0, cur_freq_1, cur_freq_2, cur_freq_3,
               min_freq_1, min_freq_2, min_freq_3,
        input  ready
    );

    modport sink (
        input  valid, kind, online_mask, policy_ok_mask,
               cur_freq_0, cur_freq_1, cur_freq_2, cur_freq_3,
               min_freq_1, min_freq_2, min_freq_3,
        output ready
    );
endinterface

interface hpg_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic [1:0]                target_core;
    logic [hpg_pkg::IVL_W-1:0] sample_interval;

    modport source (
        output valid, action, target_core, sample_interval,
        input  ready
    );

    modport sink (
        input  valid, action, target_core, sample_interval,
        output ready
    );
endinterface

// File: design/hpg_apb_regs.sv
// ----------------------------------------------------------------------------
// hpg_apb_regs
// APB register file holding enable, the frequency threshold and the
// signed wake-up and shutdown limits of the secondary cores.
// ----------------------------------------------------------------------------
module hpg_apb_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hpg_pkg::ADDR_W-1:0]  paddr,
    input  logic [hpg_pkg::DATA_W-1:0]  pwdata,
    output logic [hpg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output hpg_pkg::hpg_cfg_t           cfg
);
    import hpg_pkg::*;

    hpg_cfg_t cfg_reg;
    hpg_cfg_t cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_ENABLE:    cfg_next.enable        = pwdata[0];
                REG_THRESHOLD: cfg_next.threshold     = pwdata[FREQ_W-1:0];
                REG_UP_1:      cfg_next.up_limit[0]   = pwdata[CNT_W-1:0];
                REG_UP_2:      cfg_next.up_limit[1]   = pwdata[CNT_W-1:0];
                REG_UP_3:      cfg_next.up_limit[2]   = pwdata[CNT_W-1:0];
                REG_DOWN_1:    cfg_next.down_limit[0] = pwdata[CNT_W-1:0];
                REG_DOWN_2:    cfg_next.down_limit[1] = pwdata[CNT_W-1:0];
                REG_DOWN_3:    cfg_next.down_limit[2] = pwdata[CNT_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable        <= 1'b1;
            cfg_reg.threshold     <= RST_THRESHOLD;
            cfg_reg.up_limit[0]   <= RST_UP_1;
            cfg_reg.up_limit[1]   <= RST_UP_2;
            cfg_reg.up_limit[2]   <= RST_UP_3;
            cfg_reg.down_limit[0] <= RST_DOWN_1;
            cfg_reg.down_limit[1] <= RST_DOWN_2;
            cfg_reg.down_limit[2] <= RST_DOWN_3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back multiplexer
    always_comb
    begin
        unique case (idx)
            REG_ENABLE:    prdata = DATA_W'(cfg_reg.enable);
            REG_THRESHOLD: prdata = DATA_W'(cfg_reg.threshold);
            REG_UP_1:      prdata = DATA_W'(cfg_reg.up_limit[0]);
            REG_UP_2:      prdata = DATA_W'(cfg_reg.up_limit[1]);
            REG_UP_3:      prdata = DATA_W'(cfg_reg.up_limit[2]);
            REG_DOWN_1:    prdata = DATA_W'(cfg_reg.down_limit[0]);
            REG_DOWN_2:    prdata = DATA_W'(cfg_reg.down_limit[1]);
            REG_DOWN_3:    prdata = DATA_W'(cfg_reg.down_limit[2]);
            default:       prdata = '0;
        endcase
    end

endmodule

// File: design/hpg_cell.sv
// ----------------------------------------------------------------------------
// hpg_cell
// One secondary core: captures its frequency flags, keeps its saturating
// hotplug counter and takes part in the wake-up and shutdown scans that
// ripple along the row of cells.
// ----------------------------------------------------------------------------
module hpg_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic                         online_in,
    input  logic                         ok_in,
    input  logic [hpg_pkg::FREQ_W-1:0]   cur_freq,
    input  logic [hpg_pkg::FREQ_W-1:0]   min_freq,
    input  logic [hpg_pkg::FREQ_W-1:0]   threshold,
    input  logic [hpg_pkg::CNT_W-1:0]    up_limit,
    input  logic [hpg_pkg::CNT_W-1:0]    down_limit,
    input  hpg_pkg::hpg_ctrl_t           ctrl,
    input  logic                         wake_in,
    output logic                         wake_out,
    input  logic                         down_in,
    output logic                         down_out,
    output hpg_pkg::hpg_flags_t          flags,
    output hpg_pkg::hpg_fire_t           fire
);
    import hpg_pkg::*;

    hpg_flags_t              flags_reg;
    hpg_flags_t              flags_next;
    logic signed [CNT_W-1:0] cnt_reg;
    logic signed [CNT_W-1:0] cnt_next;
    logic                    above;
    logic                    wake_sel;
    logic                    down_sel;

    // Frequency classification of the incoming word
    always_comb
    begin
        above             = cur_freq > threshold;
        flags_next.online = online_in;
        flags_next.at_max = online_in & ok_in & above;
        flags_next.at_low = online_in & ok_in & ~above & (cur_freq <= min_freq);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

    // Scan decisions: the wake scan runs from the highest core down and stops
    // at the first offline core; the shutdown scan runs upward over online
    // cores and stops at the first one that is taken down.
    always_comb
    begin
        wake_sel  = ctrl.wake_en & wake_in & ~flags_reg.online;
        down_sel  = ctrl.down_en & down_in & flags_reg.online;
        fire.up   = wake_sel & (cnt_reg < $signed(up_limit));
        fire.down = down_sel & (cnt_reg > $signed(down_limit));
        wake_out  = wake_in & flags_reg.online;
        down_out  = down_in & ~fire.down;
    end

    // Saturating counter update
    always_comb
    begin
        priority if (fire.up)
            cnt_next = WAKE_COUNT;
        else if (wake_sel && cnt_reg != CNT_MIN)
            cnt_next = cnt_reg - 10'sd1;
        else if (fire.down)
            cnt_next = '0;
        else if (down_sel && cnt_reg != CNT_MAX)
            cnt_next = cnt_reg + 10'sd1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: design/core_hotplug_governor.sv
// ----------------------------------------------------------------------------
// core_hotplug_governor
// Hotplug decision block: a flag-capture stage, a row of per-core cells
// holding the hotplug counters, and a registered response word.
// An accepted event word passes the capture stage, then the response register.
// Throughput: one word per cycle while responses are taken; each cell's counter
// is read and written in the same cycle, so consecutive words need no spacing.
// Reset (rst_n, asynchronous, active low): counters to zero, display on,
// interval to DEFAULT_INTERVAL, registers to their reset values.
// ----------------------------------------------------------------------------
module core_hotplug_governor #(
    parameter int NUM_CORES        = 4,
    parameter int DEFAULT_INTERVAL = 1,
    parameter int MAX_INTERVAL     = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    hpg_req_if.sink                     req,
    hpg_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hpg_pkg::ADDR_W-1:0]  paddr,
    input  logic [hpg_pkg::DATA_W-1:0]  pwdata,
    output logic [hpg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import hpg_pkg::*;

    hpg_cfg_t                 cfg;
    logic                     adv;
    logic                     load;
    logic                     step;
    logic                     tick;
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    kind_t                    s1_kind_reg;
    logic                     s1_online0_reg;
    logic                     s1_max0_reg;
    logic [FREQ_W-1:0]        cur_freq [1:3];
    logic [FREQ_W-1:0]        min_freq [1:3];
    hpg_flags_t               flags    [1:NUM_CORES-1];
    hpg_fire_t                fire     [1:NUM_CORES-1];
    logic                     wake_chain [0:NUM_CORES-1];
    logic                     down_chain [1:NUM_CORES];
    hpg_ctrl_t                ctrl;
    logic                     all_max;
    logic                     any_low;
    logic                     any_up;
    logic                     any_down;
    logic [1:0]               target;
    logic                     display_on_reg;
    logic                     display_on_next;
    logic [IVL_W-1:0]         interval_reg;
    logic [IVL_W-1:0]         interval_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    action_t                  action_reg;
    action_t                  action_next;
    logic [1:0]               target_reg;
    logic [1:0]               target_next;

    // Configuration registers
    hpg_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pipeline flow control: the response register frees up when taken, and
    // the capture stage accepts whenever it is empty or moving on.
    assign adv       = ~rsp_valid_reg | rsp.ready;
    assign req.ready = adv | ~s1_valid_reg;
    assign load      = req.valid & req.ready;
    assign step      = s1_valid_reg & adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req.ready)
        begin
            s1_valid_next = req.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Capture of the word's kind and of core 0, which has no counter
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_kind_reg    <= kind_t'(req.kind);
            s1_online0_reg <= req.online_mask[0];
            s1_max0_reg    <= req.online_mask[0] & req.policy_ok_mask[0]
                              & (req.cur_freq_0 > cfg.threshold);
        end
    end

    assign cur_freq[1] = req.cur_freq_1;
    assign cur_freq[2] = req.cur_freq_2;
    assign cur_freq[3] = req.cur_freq_3;
    assign min_freq[1] = req.min_freq_1;
    assign min_freq[2] = req.min_freq_2;
    assign min_freq[3] = req.min_freq_3;

    // Global tests over the captured flags
    always_comb
    begin
        all_max = ~s1_online0_reg | s1_max0_reg;
        any_low = 1'b0;
        for (int i = 1; i < NUM_CORES; i++)
        begin
            all_max = all_max & (~flags[i].online | flags[i].at_max);
            any_low = any_low | flags[i].at_low;
        end
    end

    assign tick         = step & (s1_kind_reg == KIND_TICK) & cfg.enable;
    assign ctrl.wake_en = tick & all_max;
    assign ctrl.down_en = tick & ~all_max & any_low;

    // Row of counter cells, one per secondary core
    assign wake_chain[NUM_CORES-1] = 1'b1;
    assign down_chain[1]           = 1'b1;

    for (genvar g = 1; g < NUM_CORES; g++)
    begin : g_cell
        if (g == NUM_CORES - 1)
        begin : g_top
            hpg_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .load       (load),
                .online_in  (req.online_mask[g]),
                .ok_in      (req.policy_ok_mask[g]),
                .cur_freq   (cur_freq[g]),
                .min_freq   (min_freq[g]),
                .threshold  (cfg.threshold),
                .up_limit   (cfg.up_limit[g-1]),
                .down_limit (cfg.down_limit[g-1]),
                .ctrl       (ctrl),
                .wake_in    (wake_chain[NUM_CORES-1]),
                .wake_out   (wake_chain[g-1]),
                .down_in    (down_chain[g]),
                .down_out   (down_chain[g+1]),
                .flags      (flags[g]),
                .fire       (fire[g])
            );
        end
        else
        begin : g_mid
            hpg_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .load       (load),
                .online_in  (req.online_mask[g]),
                .ok_in      (req.policy_ok_mask[g]),
                .cur_freq   (cur_freq[g]),
                .min_freq   (min_freq[g]),
                .threshold  (cfg.threshold),
                .up_limit   (cfg.up_limit[g-1]),
                .down_limit (cfg.down_limit[g-1]),
                .ctrl       (ctrl),
                .wake_in    (wake_chain[g]),
                .wake_out   (wake_chain[g-1]),
                .down_in    (down_chain[g]),
                .down_out   (down_chain[g+1]),
                .flags      (flags[g]),
                .fire       (fire[g])
            );
        end
    end

    // Collect the single firing cell, if any
    always_comb
    begin
        any_up = 1'b0;
        target = '0;
        for (int i = 1; i < NUM_CORES; i++)
        begin
            any_up = any_up | fire[i].up;
            if (fire[i].up || fire[i].down)
            begin
                target = target | 2'(i);
            end
        end
        // The wake scan only fires when some secondary core was offline.
        any_up   = any_up & ~wake_chain[0];
        any_down = ~down_chain[NUM_CORES];
    end

    // Display state, interval and response word
    always_comb
    begin
        display_on_next = display_on_reg;
        interval_next   = interval_reg;
        action_next     = action_reg;
        target_next     = target_reg;
        rsp_valid_next  = rsp_valid_reg;
        if (adv)
        begin
            rsp_valid_next = s1_valid_reg;
        end
        if (step)
        begin
            unique case (s1_kind_reg)
                KIND_DISP_OFF:
                begin
                    display_on_next = 1'b0;
                end
                KIND_DISP_ON:
                begin
                    display_on_next = 1'b1;
                    interval_next   = IVL_W'(DEFAULT_INTERVAL);
                end
                KIND_TICK:
                begin
                    if (cfg.enable && !display_on_reg
                        && interval_reg < IVL_W'(MAX_INTERVAL))
                    begin
                        interval_next = interval_reg + 1'b1;
                    end
                end
                default:
                begin
                    interval_next = interval_reg;
                end
            endcase
            if (any_up)
            begin
                action_next = ACT_UP;
                target_next = target;
            end
            else if (any_down)
            begin
                action_next = ACT_DOWN;
                target_next = target;
            end
            else
            begin
                action_next = ACT_NONE;
                target_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_on_reg <= 1'b1;
            interval_reg   <= IVL_W'(DEFAULT_INTERVAL);
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            display_on_reg <= display_on_next;
            interval_reg   <= interval_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        target_reg <= target_next;
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.action          = action_reg;
    assign rsp.target_core     = target_reg;
    assign rsp.sample_interval = interval_reg;

endmodule
